/* hdl/kcg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcg_pkg: shared types and constants of the key click gesture detector
// Phase and event codes, register indexes, reset values and the structs
// that pass configuration and results between the modules.
// ----------------------------------------------------------------------------
package kcg_pkg;

  // widths fixed by the channel payloads
  localparam int unsigned KCG_TIME_BITS = 32;
  localparam int unsigned NOW_BITS      = 32;
  localparam int unsigned CFG_BITS      = 16;
  localparam int unsigned IDX_BITS      = 8;
  localparam int unsigned COUNT_BITS    = 2;

  // detection phases
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_PRESS_DOWN = 3'd1,
    PH_PRESSING   = 3'd2,
    PH_PRESS_UP   = 3'd3,
    PH_UPPING     = 3'd4,
    PH_CLOSING    = 3'd5
  } phase_t;

  // reported events
  typedef enum logic [2:0] {
    EV_CLICK  = 3'd0,
    EV_DOUBLE = 3'd1,
    EV_TREBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_IDLE   = 3'd4
  } event_t;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_LONG_HOLD   = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_DOUBLE_WIN  = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] REG_TREBLE_WIN  = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] REG_IDLE_RELEASE = IDX_BITS'(3);

  // register reset values
  localparam logic [CFG_BITS-1:0] LONG_HOLD_RST    = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] DOUBLE_WIN_RST   = CFG_BITS'(600);
  localparam logic [CFG_BITS-1:0] TREBLE_WIN_RST   = CFG_BITS'(900);
  localparam logic [CFG_BITS-1:0] IDLE_RELEASE_RST = CFG_BITS'(300);

  // release numbers that select double and treble checks
  localparam logic [COUNT_BITS-1:0] CNT_SECOND = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0] CNT_THIRD  = COUNT_BITS'(3);

  typedef struct packed {
    logic [CFG_BITS-1:0] long_hold_ms;
    logic [CFG_BITS-1:0] double_window_ms;
    logic [CFG_BITS-1:0] treble_window_ms;
    logic [CFG_BITS-1:0] idle_release_ms;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    event_t                event_code;
    logic [COUNT_BITS-1:0] click_count;
  } result_t;

endpackage

/* hdl/kcg_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcg_in_if: key sample channel
// One beat carries a sampled key level and a millisecond timestamp.
// ----------------------------------------------------------------------------
interface kcg_in_if import kcg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                key_level;
  logic [NOW_BITS-1:0] now_ms;

  modport source (output valid, output key_level, output now_ms, input ready);
  modport sink (input valid, input key_level, input now_ms, output ready);
endinterface

/* hdl/kcg_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcg_out_if: gesture event channel
// One beat carries an event code and the release count at that event.
// ----------------------------------------------------------------------------
interface kcg_out_if import kcg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  event_t                event_code;
  logic [COUNT_BITS-1:0] click_count;

  modport source (output valid, output event_code, output click_count, input ready);
  modport sink (input valid, input event_code, input click_count, output ready);
endinterface

/* hdl/kcg_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcg_cfg_if: configuration write channel
// One beat writes one threshold register at the given index.
// ----------------------------------------------------------------------------
interface kcg_cfg_if import kcg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IDX_BITS-1:0] reg_index;
  logic [CFG_BITS-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* hdl/kcg_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcg_cfg_regs: threshold register file
// Four 16-bit thresholds written through the configuration channel;
// writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module kcg_cfg_regs import kcg_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  kcg_cfg_if.sink       cfg_ch,
  output cfg_t          cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // always ready; each write is registered into its threshold
  assign cfg_ch.ready = 1'b1;

  // register select
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_LONG_HOLD:    cfg_nxt.long_hold_ms     = cfg_ch.wdata;
        REG_DOUBLE_WIN:   cfg_nxt.double_window_ms = cfg_ch.wdata;
        REG_TREBLE_WIN:   cfg_nxt.treble_window_ms = cfg_ch.wdata;
        REG_IDLE_RELEASE: cfg_nxt.idle_release_ms  = cfg_ch.wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_hold_ms     <= LONG_HOLD_RST;
      cfg_r.double_window_ms <= DOUBLE_WIN_RST;
      cfg_r.treble_window_ms <= TREBLE_WIN_RST;
      cfg_r.idle_release_ms  <= IDLE_RELEASE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/kcg_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcg_core: gesture state machine
// Holds the detection phase, timestamps and release count; on each step
// it advances by one sample and forms at most one event.
// ----------------------------------------------------------------------------
module kcg_core import kcg_pkg::*; #(
  parameter int unsigned TIME_BITS = KCG_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 key_level,
  input  logic [TIME_BITS-1:0] now,
  input  cfg_t                 cfg,
  output result_t              res
);

  phase_t                phase_r, phase_nxt;
  logic                  prev_level_r;
  logic [TIME_BITS-1:0]  start_r, start_nxt;
  logic [TIME_BITS-1:0]  down_r, down_nxt;
  logic [TIME_BITS-1:0]  up_r, up_nxt;
  logic [COUNT_BITS-1:0] releases_r, releases_nxt;

  logic [TIME_BITS-1:0]  hold_el;
  logic [TIME_BITS-1:0]  since_start;
  logic [TIME_BITS-1:0]  release_el;

  // elapsed times, wrapping at the timestamp width
  assign hold_el     = now - down_r;
  assign since_start = now - start_r;
  assign release_el  = now - up_r;

  // next phase and event
  always_comb begin
    phase_nxt      = phase_r;
    start_nxt      = start_r;
    down_nxt       = down_r;
    up_nxt         = up_r;
    releases_nxt   = releases_r;
    res            = '0;
    res.event_code = EV_CLICK;
    case (phase_r)
      PH_IDLE: begin
        // falling edge opens a detection
        if (prev_level_r && !key_level) begin
          start_nxt    = now;
          down_nxt     = now;
          releases_nxt = '0;
          phase_nxt    = PH_PRESS_DOWN;
        end
      end
      PH_PRESS_DOWN: begin
        down_nxt  = now;
        phase_nxt = PH_PRESSING;
      end
      PH_PRESSING: begin
        if (!key_level) begin
          if (hold_el >= TIME_BITS'(cfg.long_hold_ms)) begin
            res.valid       = 1'b1;
            res.event_code  = EV_LONG;
            res.click_count = releases_r;
            phase_nxt       = PH_CLOSING;
          end
        end else begin
          phase_nxt = PH_PRESS_UP;
        end
      end
      PH_PRESS_UP: begin
        // every release reports; the third one ends detection
        up_nxt          = now;
        releases_nxt    = releases_r + COUNT_BITS'(1);
        phase_nxt       = PH_UPPING;
        res.valid       = 1'b1;
        res.click_count = releases_nxt;
        if (releases_nxt == CNT_SECOND) begin
          if (since_start < TIME_BITS'(cfg.double_window_ms)) res.event_code = EV_DOUBLE;
        end else if (releases_nxt == CNT_THIRD) begin
          if (since_start < TIME_BITS'(cfg.treble_window_ms)) res.event_code = EV_TREBLE;
          phase_nxt = PH_CLOSING;
        end
      end
      PH_UPPING: begin
        if (key_level) begin
          if (release_el >= TIME_BITS'(cfg.idle_release_ms)) phase_nxt = PH_CLOSING;
        end else begin
          phase_nxt = PH_PRESS_DOWN;
        end
      end
      default: begin
        // closing and unused codes report idle
        releases_nxt   = '0;
        phase_nxt      = PH_IDLE;
        res.valid      = 1'b1;
        res.event_code = EV_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      prev_level_r <= 1'b1;
      releases_r   <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      prev_level_r <= key_level;
      releases_r   <= releases_nxt;
    end
  end

  // timestamps
  always_ff @(posedge clk) begin
    if (step) begin
      start_r <= start_nxt;
      down_r  <= down_nxt;
      up_r    <= up_nxt;
    end
  end

`ifndef SYNTHESIS
  a_close_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_CLOSING |=> phase_r == PH_IDLE)
    else $error("closing phase did not return to idle");

  a_long_closes: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid && res.event_code == EV_LONG |=> phase_r == PH_CLOSING)
    else $error("long hold did not lead to closing");

  a_treble_third: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.event_code == EV_TREBLE |-> res.click_count == CNT_THIRD)
    else $error("treble click reported on other than third release");
`endif

endmodule

/* hdl/key_click_gesture_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_click_gesture_detector: click, double, treble and long hold detector
// Samples a key level with a timestamp and reports gesture events.
//
//   channel  dir  beat
//   in_ch    in   key_level, now_ms (one poll sample)
//   out_ch   out  event_code, click_count (zero or one per sample)
//   cfg_ch   in   reg_index, wdata (one threshold write)
//
// One sample per cycle while no event waits; an event leaves through the
// input register, then the state update into the result register.
// The result register decouples the sides: while an event waits, the
// sample in the input register holds and in_ch.ready drops.
// Synchronous active-low reset; thresholds reset to 1000/600/900/300 ms.
// ----------------------------------------------------------------------------
module key_click_gesture_detector import kcg_pkg::*; #(
  parameter int unsigned TIME_BITS = KCG_TIME_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  kcg_in_if.sink   in_ch,
  kcg_out_if.source out_ch,
  kcg_cfg_if.sink  cfg_ch
);

  logic                  in_valid_r, in_valid_nxt;
  logic                  in_level_r;
  logic [NOW_BITS-1:0]   in_now_r;
  logic                  out_valid_r, out_valid_nxt;
  event_t                out_event_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic                  advance;
  logic                  in_take;
  cfg_t                  cfg;
  result_t               res;

  kcg_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  kcg_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .key_level (in_level_r),
    .now       (TIME_BITS'(in_now_r)),
    .cfg       (cfg),
    .res       (res)
  );

  // the held sample moves on when the result register can take its event
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = res.valid;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_level_r <= in_ch.key_level;
      in_now_r   <= in_ch.now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_event_r <= res.event_code;
      out_count_r <= res.click_count;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_code  = out_event_r;
  assign out_ch.click_count = out_count_r;

`ifndef SYNTHESIS
  a_hold_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("held sample dropped before processing");

  a_event_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.valid |=> out_valid_r && out_event_r == $past(res.event_code))
    else $error("event not captured in result register");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> in_valid_r && out_valid_r)
    else $error("input stalled without a waiting event");
`endif

endmodule
